@@ rtl/core/dxtbd_pkg.sv @@
// shared types and color arithmetic for the dxt block decoder
`timescale 1ns / 1ps
`default_nettype none

package dxtbd_pkg;

  localparam int unsigned NumTexels = 16;
  localparam logic [3:0]  LastTexel = 4'd15;

  // one decoded block as it travels from the front end to the texel emitter
  typedef struct packed {
    logic             cmd;
    logic [31:0]      index_bits;
    logic [63:0]      alpha_bits;
    logic [3:0][7:0]  pal_r;
    logic [3:0][7:0]  pal_g;
    logic [3:0][7:0]  pal_b;
    logic [3:0][7:0]  pal_a;
  } blk_t;

  // floor(v*255/31): reciprocal multiply, exact for every 5-bit input
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [12:0] x;
    logic [26:0] p;
    x = 13'(v) * 13'd255;
    p = 27'(x) * 27'd8457;
    return p[25:18];
  endfunction

  // floor(v*255/63): reciprocal multiply, exact for every 6-bit input
  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [13:0] x;
    logic [29:0] p;
    x = 14'(v) * 14'd255;
    p = 30'(x) * 30'd16645;
    return p[27:20];
  endfunction

  // floor(x/3) for x below 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dxtbd_front.sv @@
// front end: takes a compressed block, widens endpoints, builds the palette
`timescale 1ns / 1ps
`default_nettype none

module dxtbd_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic           cmd_i,
  input  wire logic [15:0]    color0_i,
  input  wire logic [15:0]    color1_i,
  input  wire logic [31:0]    index_bits_i,
  input  wire logic [63:0]    alpha_bits_i,
  input  wire logic           full_i,
  output logic                push_o,
  output dxtbd_pkg::blk_t     entry_o
);

  logic        valid_q, valid_d;
  logic        accept;
  logic        cmd_q, gt_q;
  logic [31:0] idx_q;
  logic [63:0] alpha_q;
  logic [7:0]  r0_q, g0_q, b0_q, r1_q, g1_q, b1_q;

  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      gt_q    <= color0_i > color1_i;
      idx_q   <= index_bits_i;
      alpha_q <= alpha_bits_i;
      r0_q    <= dxtbd_pkg::widen5(color0_i[15:11]);
      g0_q    <= dxtbd_pkg::widen6(color0_i[10:5]);
      b0_q    <= dxtbd_pkg::widen5(color0_i[4:0]);
      r1_q    <= dxtbd_pkg::widen5(color1_i[15:11]);
      g1_q    <= dxtbd_pkg::widen6(color1_i[10:5]);
      b1_q    <= dxtbd_pkg::widen5(color1_i[4:0]);
    end
  end

  // blend entries: thirds when color0 > color1, else average plus transparent magenta
  function automatic logic [7:0] third(input logic [7:0] a, input logic [7:0] b);
    logic [9:0] s;
    s = {1'b0, a, 1'b0} + {2'b00, b};
    return dxtbd_pkg::div3(s);
  endfunction

  function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

  always_comb begin
    entry_o.cmd        = cmd_q;
    entry_o.index_bits = idx_q;
    entry_o.alpha_bits = alpha_q;
    entry_o.pal_r[0]   = r0_q;
    entry_o.pal_g[0]   = g0_q;
    entry_o.pal_b[0]   = b0_q;
    entry_o.pal_a[0]   = 8'hFF;
    entry_o.pal_r[1]   = r1_q;
    entry_o.pal_g[1]   = g1_q;
    entry_o.pal_b[1]   = b1_q;
    entry_o.pal_a[1]   = 8'hFF;
    entry_o.pal_a[2]   = 8'hFF;
    if (gt_q) begin
      entry_o.pal_r[2] = third(r0_q, r1_q);
      entry_o.pal_g[2] = third(g0_q, g1_q);
      entry_o.pal_b[2] = third(b0_q, b1_q);
      entry_o.pal_r[3] = third(r1_q, r0_q);
      entry_o.pal_g[3] = third(g1_q, g0_q);
      entry_o.pal_b[3] = third(b1_q, b0_q);
      entry_o.pal_a[3] = 8'hFF;
    end else begin
      entry_o.pal_r[2] = half(r0_q, r1_q);
      entry_o.pal_g[2] = half(g0_q, g1_q);
      entry_o.pal_b[2] = half(b0_q, b1_q);
      entry_o.pal_r[3] = 8'hFF;
      entry_o.pal_g[3] = 8'h00;
      entry_o.pal_b[3] = 8'hFF;
      entry_o.pal_a[3] = 8'h00;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dxtbd_fifo.sv @@
// two-entry queue of decoded blocks between front end and texel emitter
`timescale 1ns / 1ps
`default_nettype none

module dxtbd_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire dxtbd_pkg::blk_t  entry_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output dxtbd_pkg::blk_t       head_o
);

  dxtbd_pkg::blk_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dxtbd_back.sv @@
// texel emitter: walks the sixteen indices of the head block into the output register
`timescale 1ns / 1ps
`default_nettype none

module dxtbd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire dxtbd_pkg::blk_t  head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [3:0]            texel_o,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o,
  output logic [7:0]            alpha_o,
  output logic                  last_o
);

  logic       valid_q, valid_d;
  logic [3:0] cnt_q, cnt_d;
  logic       advance, load;
  logic [1:0] sel;
  logic [3:0] nib;
  logic [7:0] alpha_d;

  assign advance = !valid_q || !out_stall_i;
  assign load    = advance && !empty_i;
  assign pop_o   = load && (cnt_q == dxtbd_pkg::LastTexel);
  assign sel     = head_i.index_bits[{cnt_q, 1'b0} +: 2];
  assign nib     = head_i.alpha_bits[{cnt_q, 2'b00} +: 4];
  assign alpha_d = head_i.cmd ? {nib, nib} : head_i.pal_a[sel];

  always_comb begin
    valid_d = advance ? !empty_i : valid_q;
    cnt_d   = load ? cnt_q + 4'd1 : cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 4'd0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      texel_o <= cnt_q;
      red_o   <= head_i.pal_r[sel];
      green_o <= head_i.pal_g[sel];
      blue_o  <= head_i.pal_b[sel];
      alpha_o <= alpha_d;
      last_o  <= cnt_q == dxtbd_pkg::LastTexel;
    end
  end

  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

@@ rtl/core/dxt_block_decoder_unit.sv @@
// the first texel of a block passes through the front register and a queue entry into the output register
// throughput: one texel per cycle while a block is queued and the output is not stalled,
//   set by the single texel emitter draining the block queue
// up to four blocks may be in flight (front register, two queue entries, emitter)
// reset clears all valid flags, queue pointers and the texel counter; data registers keep junk
`timescale 1ns / 1ps
`default_nettype none

module dxt_block_decoder_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic         cmd_i,
  input  wire logic [15:0]  color0_i,
  input  wire logic [15:0]  color1_i,
  input  wire logic [31:0]  index_bits_i,
  input  wire logic [63:0]  alpha_bits_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [3:0]        texel_o,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic [7:0]        alpha_o,
  output logic              last_o
);

  dxtbd_pkg::blk_t push_entry;
  dxtbd_pkg::blk_t head_entry;
  logic            push, full, pop, empty;

  dxtbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .color0_i     (color0_i),
    .color1_i     (color1_i),
    .index_bits_i (index_bits_i),
    .alpha_bits_i (alpha_bits_i),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  dxtbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_entry)
  );

  dxtbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .texel_o     (texel_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_o     (alpha_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/dxtbd_checker.sv @@
// port-level checks on the texel stream of the dxt block decoder
`timescale 1ns / 1ps
`default_nettype none

module dxtbd_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        out_valid_o,
  input  wire logic        out_stall_i,
  input  wire logic [3:0]  texel_o,
  input  wire logic [7:0]  red_o,
  input  wire logic [7:0]  green_o,
  input  wire logic [7:0]  blue_o,
  input  wire logic [7:0]  alpha_o,
  input  wire logic        last_o
);

  // stalled request holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(texel_o) && $stable(red_o)
      && $stable(green_o) && $stable(blue_o) && $stable(alpha_o) && $stable(last_o))
    else $error("output request changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (texel_o == 4'd15)))
    else $error("last flag does not match texel position");

  // texels of a block come in raster order with no gap in numbering
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      !out_valid_o || (texel_o == $past(texel_o) + 4'd1))
    else $error("texel sequence skipped or repeated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !out_valid_o || (texel_o == 4'd0))
    else $error("new block does not start at texel zero");

endmodule

bind dxt_block_decoder_unit dxtbd_checker u_dxtbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .texel_o     (texel_o),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o),
  .alpha_o     (alpha_o),
  .last_o      (last_o)
);

`default_nettype wire

@@ tb/sv/dxt_block_decoder_unit_tb.sv @@
// self-checking testbench for the dxt block decoder unit
`timescale 1ns / 1ps

module dxt_block_decoder_unit_tb;

  localparam logic CmdDxt1 = 1'b0;
  localparam logic CmdDxt3 = 1'b1;
  localparam int   CycleLimit = 200000;
  localparam int   LongHoldCycles = 300;
  localparam int   TailCycles = 40;

  typedef struct packed {
    logic        cmd;
    logic [15:0] color0;
    logic [15:0] color1;
    logic [31:0] index_bits;
    logic [63:0] alpha_bits;
  } dxt_block_t;

  typedef struct packed {
    logic [3:0] texel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } texel_rgba_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  dxt_block_t  offered = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  texel;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        last;

  dxt_block_t  pending_blocks[$];
  texel_rgba_t expected_texels[$];
  texel_rgba_t head_texel;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  logic        hold_request = 1'b0;
  logic        long_hold = 1'b0;

  dxt_block_decoder_unit uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (offered.cmd),
    .color0_i     (offered.color0),
    .color1_i     (offered.color1),
    .index_bits_i (offered.index_bits),
    .alpha_bits_i (offered.alpha_bits),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .texel_o      (texel),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue),
    .alpha_o      (alpha),
    .last_o       (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] widen_channel(input int unsigned v, input int unsigned full);
    return 8'((v * 255) / full);
  endfunction

  // expands one block into its sixteen texels and queues them
  function automatic void decode_block(input dxt_block_t b);
    logic [7:0]  pr [4];
    logic [7:0]  pg [4];
    logic [7:0]  pb [4];
    logic [7:0]  pa [4];
    logic [1:0]  sel;
    logic [3:0]  nib;
    texel_rgba_t t;
    pr[0] = widen_channel(b.color0[15:11], 31);
    pg[0] = widen_channel(b.color0[10:5], 63);
    pb[0] = widen_channel(b.color0[4:0], 31);
    pr[1] = widen_channel(b.color1[15:11], 31);
    pg[1] = widen_channel(b.color1[10:5], 63);
    pb[1] = widen_channel(b.color1[4:0], 31);
    pa[0] = 8'd255;
    pa[1] = 8'd255;
    pa[2] = 8'd255;
    if (b.color0 > b.color1) begin
      pr[2] = 8'((2 * int'(pr[0]) + int'(pr[1])) / 3);
      pg[2] = 8'((2 * int'(pg[0]) + int'(pg[1])) / 3);
      pb[2] = 8'((2 * int'(pb[0]) + int'(pb[1])) / 3);
      pr[3] = 8'((int'(pr[0]) + 2 * int'(pr[1])) / 3);
      pg[3] = 8'((int'(pg[0]) + 2 * int'(pg[1])) / 3);
      pb[3] = 8'((int'(pb[0]) + 2 * int'(pb[1])) / 3);
      pa[3] = 8'd255;
    end else begin
      pr[2] = 8'((int'(pr[0]) + int'(pr[1])) / 2);
      pg[2] = 8'((int'(pg[0]) + int'(pg[1])) / 2);
      pb[2] = 8'((int'(pb[0]) + int'(pb[1])) / 2);
      // transparent magenta
      pr[3] = 8'd255;
      pg[3] = 8'd0;
      pb[3] = 8'd255;
      pa[3] = 8'd0;
    end
    for (int i = 0; i < dxtbd_pkg::NumTexels; i++) begin
      sel = b.index_bits[2*i +: 2];
      nib = b.alpha_bits[4*i +: 4];
      t.texel = 4'(i);
      t.red = pr[sel];
      t.green = pg[sel];
      t.blue = pb[sel];
      t.alpha = (b.cmd == CmdDxt3) ? {nib, nib} : pa[sel];
      t.last = (4'(i) == dxtbd_pkg::LastTexel);
      expected_texels.push_back(t);
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // request driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        decode_block(offered);
      end
      if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered <= pending_blocks.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // texel monitor and receiver stall
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_texels.size() == 0) begin
          $error("texel %0d arrived with nothing expected", texel);
          error_count++;
        end else begin
          head_texel = expected_texels.pop_front();
          check_field("texel", head_texel.texel, texel);
          check_field("red", head_texel.red, red);
          check_field("green", head_texel.green, green);
          check_field("blue", head_texel.blue, blue);
          check_field("alpha", head_texel.alpha, alpha);
          check_field("last", head_texel.last, last);
        end
      end
      out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (hold_request);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (LongHoldCycles) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_block(input logic cmd, input logic [15:0] c0, input logic [15:0] c1,
                           input logic [31:0] idx, input logic [63:0] abits);
    pending_blocks.push_back('{cmd, c0, c1, idx, abits});
  endtask

  task automatic add_random_blocks(input int count);
    dxt_block_t b;
    repeat (count) begin
      b.cmd = $urandom_range(1) ? CmdDxt3 : CmdDxt1;
      b.color0 = 16'($urandom);
      b.color1 = 16'($urandom);
      case ($urandom_range(7))
        0: b.color1 = b.color0;
        // endpoints one bit apart, either order
        1: b.color1 = b.color0 ^ 16'(1 << $urandom_range(15));
        default: ;
      endcase
      b.index_bits = $urandom;
      b.alpha_bits = {$urandom, $urandom};
      pending_blocks.push_back(b);
    end
  endtask

  // sender holds back until every queued request has produced all its texels
  task automatic drain();
    while (pending_blocks.size() != 0 || in_valid || expected_texels.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    add_random_blocks(count);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    add_block(CmdDxt1, 16'hFFFF, 16'h0000, 32'hE4E4_E4E4, 64'h0);
    add_block(CmdDxt1, 16'h0000, 16'hFFFF, 32'hE4E4_E4E4, 64'h0);
    add_block(CmdDxt1, 16'h8410, 16'h8410, 32'hFFFF_FFFF, 64'h0);
    add_block(CmdDxt1, 16'hFFFF, 16'hFFFE, 32'h5555_5555, 64'hFFFF_FFFF_FFFF_FFFF);
    add_block(CmdDxt1, 16'h0001, 16'h0000, 32'h0000_0000, 64'h0);
    add_block(CmdDxt1, 16'h07E0, 16'hF81F, 32'h1B1B_1B1B, 64'h0123_4567_89AB_CDEF);
    add_block(CmdDxt3, 16'hF800, 16'h07E0, 32'h1B1B_1B1B, 64'hFEDC_BA98_7654_3210);
    add_block(CmdDxt3, 16'h001F, 16'hF800, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_block(CmdDxt3, 16'h0000, 16'h0000, 32'h0000_0000, 64'h0);
    add_block(CmdDxt3, 16'hFFFF, 16'hFFFF, 32'hAAAA_AAAA, 64'hFFFF_FFFF_FFFF_FFFF);
    add_block(CmdDxt3, 16'h7BEF, 16'h8410, 32'h2727_2727, 64'h0123_4567_89AB_CDEF);
    add_block(CmdDxt3, 16'h8410, 16'h7BEF, 32'hE4E4_E4E4, 64'h5A5A_A5A5_0F0F_F0F0);
    drain();

    hold_request = 1'b1;
    run_phase(0, 0, 40);
    run_phase(72, 0, 45);
    run_phase(0, 72, 45);
    run_phase(37, 37, 50);

    repeat (TailCycles) @(posedge clk);
    if (error_count == 0 && expected_texels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ dxt_block_decoder_unit.f @@
rtl/core/dxtbd_pkg.sv
rtl/core/dxtbd_front.sv
rtl/core/dxtbd_fifo.sv
rtl/core/dxtbd_back.sv
rtl/core/dxt_block_decoder_unit.sv
rtl/core/dxtbd_checker.sv
tb/sv/dxt_block_decoder_unit_tb.sv
